[rtl/mpep_pkg.sv]
// shared types, constants and helpers for the madt processor entry parser
package mpep_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] ENTRIES_START = 32'h0000_002c;
  localparam logic [31:0] SIG_LEN       = 32'h0000_0004;
  localparam logic [31:0] HDR_LEN       = 32'h0000_0008;
  localparam logic [31:0] MAX_POS       = 32'hffff_ffff;

  localparam logic [7:0] ENTRY_TYPE_LAPIC = 8'h00;
  localparam logic [7:0] ENTRY_MIN_LEN    = 8'h08;

  // offset of the current byte inside the entry, saturated
  localparam int unsigned OFF_W = 4;
  localparam logic [OFF_W-1:0] OFF_TYPE  = 4'd0;
  localparam logic [OFF_W-1:0] OFF_LEN   = 4'd1;
  localparam logic [OFF_W-1:0] OFF_PROC  = 4'd2;
  localparam logic [OFF_W-1:0] OFF_APIC  = 4'd3;
  localparam logic [OFF_W-1:0] OFF_FLAG0 = 4'd4;
  localparam logic [OFF_W-1:0] OFF_FLAG3 = 4'd7;
  localparam logic [OFF_W-1:0] OFF_SAT   = 4'd8;

  localparam logic KIND_REC  = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_TRUNC      = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_ZERO_ENTRY = 3'd4
  } status_e;

  // one queue entry: an optional record followed by an optional status
  typedef struct packed {
    logic        has_rec;
    logic        has_stat;
    logic [7:0]  proc_id;
    logic [7:0]  apic_id;
    logic [31:0] flags;
    status_e     status;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0: val = 8'h41;
      2'd1: val = 8'h50;
      2'd2: val = 8'h49;
      2'd3: val = 8'h43;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[rtl/mpep_front.sv]
// front end: tracks table position, header, checksum and entry walk
module mpep_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  output logic                  push_o,
  output mpep_pkg::result_t     push_data_o
);

  logic [31:0] pos_q, pos_d;
  logic [31:0] tl_q, tl_d;
  logic [7:0]  sum_q, sum_d;
  logic        sig_bad_q, sig_bad_d;
  logic [31:0] next_q, next_d;
  logic [7:0]  etype_q, etype_d;
  logic [7:0]  esize_q, esize_d;
  logic [7:0]  pid_q, pid_d;
  logic [7:0]  aid_q, aid_d;
  logic [31:0] flags_q, flags_d;
  logic        zero_q, zero_d;
  logic [mpep_pkg::OFF_W-1:0] off_q, off_d;

  logic              in_body;
  logic              rec;
  logic [32:0]       next_sum;
  mpep_pkg::status_e st;

  always_comb begin
    sig_bad_d = sig_bad_q;
    tl_d      = tl_q;
    sum_d     = sum_q;
    next_d    = next_q;
    etype_d   = etype_q;
    esize_d   = esize_q;
    pid_d     = pid_q;
    aid_d     = aid_q;
    flags_d   = flags_q;
    zero_d    = zero_q;
    rec       = 1'b0;
    next_sum  = {1'b0, pos_q} + 33'(data_byte_i - 8'd1);
    off_d     = (off_q == mpep_pkg::OFF_SAT) ? mpep_pkg::OFF_SAT : off_q + 4'd1;

    if (pos_q < mpep_pkg::SIG_LEN && data_byte_i != mpep_pkg::sig_byte(pos_q[1:0])) begin
      sig_bad_d = 1'b1;
    end
    // length field sits in bytes 4 to 7
    if (pos_q[31:2] == 30'd1) begin
      tl_d[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
    end
    if (pos_q < mpep_pkg::HDR_LEN || pos_q < tl_q) begin
      sum_d = sum_q + data_byte_i;
    end

    in_body = (pos_q >= mpep_pkg::HDR_LEN) && (pos_q < tl_q) && !zero_q;
    if (in_body) begin
      priority if (pos_q == next_q) begin
        etype_d = data_byte_i;
        off_d   = mpep_pkg::OFF_LEN;
      end else if (off_q == mpep_pkg::OFF_LEN) begin
        esize_d = data_byte_i;
        if (data_byte_i == 8'd0) begin
          zero_d = 1'b1;
        end else begin
          // entry start plus size, saturated
          next_d = next_sum[32] ? mpep_pkg::MAX_POS : next_sum[31:0];
        end
      end else if (esize_q >= mpep_pkg::ENTRY_MIN_LEN && off_q >= mpep_pkg::OFF_PROC &&
                   off_q <= mpep_pkg::OFF_FLAG3) begin
        if (off_q == mpep_pkg::OFF_PROC) begin
          pid_d = data_byte_i;
        end else if (off_q == mpep_pkg::OFF_APIC) begin
          aid_d = data_byte_i;
        end else begin
          flags_d[{off_q[1:0], 3'b000} +: 8] = data_byte_i;
        end
        if (off_q == mpep_pkg::OFF_FLAG3 && etype_q == mpep_pkg::ENTRY_TYPE_LAPIC) begin
          rec = 1'b1;
        end
      end else begin
        // remaining entry bytes carry nothing we keep
      end
    end

    pos_d = (pos_q == mpep_pkg::MAX_POS) ? pos_q : pos_q + 32'd1;

    priority if (sig_bad_d || pos_d < mpep_pkg::SIG_LEN) begin
      st = mpep_pkg::ST_BAD_SIG;
    end else if (pos_d < mpep_pkg::HDR_LEN || tl_d < mpep_pkg::HDR_LEN || pos_d < tl_d) begin
      st = mpep_pkg::ST_TRUNC;
    end else if (sum_d != 8'd0) begin
      st = mpep_pkg::ST_BAD_SUM;
    end else if (zero_d) begin
      st = mpep_pkg::ST_ZERO_ENTRY;
    end else begin
      st = mpep_pkg::ST_OK;
    end
  end

  assign push_o               = accept_i && (rec || last_i);
  assign push_data_o.has_rec  = rec;
  assign push_data_o.has_stat = last_i;
  assign push_data_o.proc_id  = pid_q;
  assign push_data_o.apic_id  = aid_q;
  assign push_data_o.flags    = flags_d;
  assign push_data_o.status   = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      tl_q      <= '0;
      sum_q     <= '0;
      sig_bad_q <= 1'b0;
      next_q    <= mpep_pkg::ENTRIES_START;
      etype_q   <= '0;
      esize_q   <= '0;
      pid_q     <= '0;
      aid_q     <= '0;
      flags_q   <= '0;
      zero_q    <= 1'b0;
      off_q     <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        // end of table: back to the start for the next one
        pos_q     <= '0;
        tl_q      <= '0;
        sum_q     <= '0;
        sig_bad_q <= 1'b0;
        next_q    <= mpep_pkg::ENTRIES_START;
        etype_q   <= '0;
        esize_q   <= '0;
        pid_q     <= '0;
        aid_q     <= '0;
        flags_q   <= '0;
        zero_q    <= 1'b0;
        off_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        tl_q      <= tl_d;
        sum_q     <= sum_d;
        sig_bad_q <= sig_bad_d;
        next_q    <= next_d;
        etype_q   <= etype_d;
        esize_q   <= esize_d;
        pid_q     <= pid_d;
        aid_q     <= aid_d;
        flags_q   <= flags_d;
        zero_q    <= zero_d;
        off_q     <= off_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_off_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= mpep_pkg::OFF_SAT)
    else $error("entry offset out of range");
  a_zero_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q && accept_i && !last_i |=> zero_q && $stable(next_q))
    else $error("entry walk moved after zero-length entry");
`endif

endmodule

[rtl/mpep_queue.sv]
// short result queue between the front end and the output stage
module mpep_queue #(
  parameter int unsigned Depth = mpep_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mpep_pkg::result_t push_data_i,
  input  logic              pop_i,
  output mpep_pkg::result_t head_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mpep_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
`endif

endmodule

[rtl/mpep_back.sv]
// output stage: sends the record and then the status of each queue entry, whichever of the two it holds
module mpep_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpep_pkg::result_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [7:0]        acpi_processor_id_o,
  output logic [7:0]        apic_id_o,
  output logic [31:0]       entry_flags_o,
  output logic [2:0]        status_o,
  output logic              final_res_o
);

  // set once the record of a two-result entry has gone out
  logic stat_phase_q, stat_phase_d;
  logic show_stat;
  logic xfer;

  assign show_stat   = stat_phase_q || !head_i.has_rec;
  assign out_valid_o = !empty_i;
  assign xfer        = out_valid_o && !out_stall_i;

  assign kind_o              = show_stat ? mpep_pkg::KIND_STAT : mpep_pkg::KIND_REC;
  assign acpi_processor_id_o = show_stat ? 8'd0 : head_i.proc_id;
  assign apic_id_o           = show_stat ? 8'd0 : head_i.apic_id;
  assign entry_flags_o       = show_stat ? 32'd0 : head_i.flags;
  assign status_o            = show_stat ? 3'(head_i.status) : 3'(mpep_pkg::ST_OK);
  assign final_res_o         = show_stat || !head_i.has_stat;

  assign pop_o = xfer && final_res_o;

  always_comb begin
    stat_phase_d = stat_phase_q;
    if (xfer) begin
      stat_phase_d = !final_res_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_phase_q <= 1'b0;
    end else begin
      stat_phase_q <= stat_phase_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_needs_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_phase_q |-> !empty_i && head_i.has_stat && head_i.has_rec)
    else $error("status phase without a pending status");
`endif

endmodule

[rtl/madt_processor_entry_parser_top.sv]
// top level of the madt processor entry parser
// a result is written into the result queue when the byte that causes it is taken
// throughput: one byte per cycle while not stalled; a record goes out before its status
// input stalls only while the result queue (QueueDepth entries) is full
// reset: asynchronous, active low; parser returns to table start, queue empties
// the parser also returns to table start after each byte marked last
module madt_processor_entry_parser_top #(
  parameter int unsigned QueueDepth = mpep_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  acpi_processor_id_o,
  output logic [7:0]  apic_id_o,
  output logic [31:0] entry_flags_o,
  output logic [2:0]  status_o,
  output logic        final_res_o
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;
  mpep_pkg::result_t push_data;
  mpep_pkg::result_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  mpep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mpep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  mpep_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .empty_i             (empty),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .acpi_processor_id_o (acpi_processor_id_o),
    .apic_id_o           (apic_id_o),
    .entry_flags_o       (entry_flags_o),
    .status_o            (status_o),
    .final_res_o         (final_res_o)
  );

`ifndef NO_ASSERTIONS
  a_stat_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == mpep_pkg::KIND_STAT |-> final_res_o)
    else $error("status transfer not marked final");
`endif

endmodule

[bench/tb.sv]
// self-checking testbench for the madt processor entry parser
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam logic [31:0] SIG_TEXT = "APIC";

  // short tables: {last, byte}
  localparam logic [8:0] SHORT_TABLES [23] = '{
    9'h141,                                                 // one byte, signature cut short
    9'h1ff,
    9'h100,
    9'h041, 9'h050, 9'h049, 9'h143,                         // signature only
    9'h041, 9'h050, 9'h049, 9'h043, 9'h000, 9'h000, 9'h000, 9'h100,  // declared length 0
    9'h041, 9'h050, 9'h049, 9'h043, 9'h008, 9'h000, 9'h000, 9'h100   // header only
  };

  typedef struct packed {
    logic              kind;
    logic [7:0]        proc_id;
    logic [7:0]        apic_id;
    logic [31:0]       flags;
    mpep_pkg::status_e status;
    logic              fin;
  } madt_result_t;

  class madt_scoreboard;
    logic [31:0] byte_pos;
    logic [31:0] tbl_len;
    logic [31:0] next_off;
    logic [31:0] entry_base;
    logic [7:0]  sum;
    logic [7:0]  etype;
    logic [7:0]  esize;
    logic [7:0]  proc_id;
    logic [7:0]  apic_id;
    logic [31:0] flags;
    logic        sig_bad;
    logic        zero_seen;
    madt_result_t pending_results[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_pos   = '0;
      tbl_len    = '0;
      next_off   = mpep_pkg::ENTRIES_START;
      entry_base = '0;
      sum        = '0;
      etype      = '0;
      esize      = '0;
      proc_id    = '0;
      apic_id    = '0;
      flags      = '0;
      sig_bad    = 1'b0;
      zero_seen  = 1'b0;
    endfunction

    // one accepted byte: update the walk and queue what it produces
    function void take_byte(logic [7:0] b, logic l);
      logic [31:0] pos;
      longint unsigned p;
      longint unsigned s;
      longint unsigned nx;
      int d;
      mpep_pkg::status_e st;
      pos = byte_pos;
      p = pos;
      s = entry_base;
      if (pos < mpep_pkg::SIG_LEN && b != SIG_TEXT[8*(3-pos[1:0]) +: 8]) sig_bad = 1'b1;
      if (pos >= mpep_pkg::SIG_LEN && pos < mpep_pkg::HDR_LEN) tbl_len[8*pos[1:0] +: 8] = b;
      if (pos < mpep_pkg::HDR_LEN || pos < tbl_len) sum = sum + b;
      if (pos >= mpep_pkg::HDR_LEN && pos < tbl_len && !zero_seen) begin
        if (pos == next_off) begin
          etype = b;
          entry_base = pos;
        end else if (p == s + 1) begin
          esize = b;
          if (b == 8'h00) begin
            zero_seen = 1'b1;
          end else begin
            nx = s + b;
            next_off = (nx > mpep_pkg::MAX_POS) ? mpep_pkg::MAX_POS : nx[31:0];
          end
        end else if (esize >= mpep_pkg::ENTRY_MIN_LEN && p >= s + 2 && p <= s + 7) begin
          d = int'(p - s);
          if (d == 2) proc_id = b;
          else if (d == 3) apic_id = b;
          else flags[8*(d-4) +: 8] = b;
          if (d == 7 && etype == mpep_pkg::ENTRY_TYPE_LAPIC)
            pending_results.push_back(madt_result_t'{mpep_pkg::KIND_REC, proc_id, apic_id,
                                                      flags, mpep_pkg::ST_OK, !l});
        end
      end
      if (pos < mpep_pkg::MAX_POS) byte_pos = pos + 1;
      if (l) begin
        if (sig_bad || byte_pos < mpep_pkg::SIG_LEN) st = mpep_pkg::ST_BAD_SIG;
        else if (byte_pos < mpep_pkg::HDR_LEN || tbl_len < mpep_pkg::HDR_LEN ||
                 byte_pos < tbl_len) st = mpep_pkg::ST_TRUNC;
        else if (sum != 8'h00) st = mpep_pkg::ST_BAD_SUM;
        else if (zero_seen) st = mpep_pkg::ST_ZERO_ENTRY;
        else st = mpep_pkg::ST_OK;
        pending_results.push_back(madt_result_t'{mpep_pkg::KIND_STAT, 8'h00, 8'h00, 32'h0,
                                                  st, 1'b1});
        restart();
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(madt_result_t got);
      madt_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding: kind %0d status %0d",
               got.kind, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("acpi_processor_id", 32'(want.proc_id), 32'(got.proc_id));
      compare("apic_id", 32'(want.apic_id), 32'(got.apic_id));
      compare("entry_flags", want.flags, got.flags);
      compare("status", 32'(want.status), 32'(got.status));
      compare("final_res", 32'(want.fin), 32'(got.fin));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  acpi_processor_id_o;
  logic [7:0]  apic_id_o;
  logic [31:0] entry_flags_o;
  logic [2:0]  status_o;
  logic        final_res_o;

  madt_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  madt_processor_entry_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .last_i,
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .acpi_processor_id_o,
    .apic_id_o,
    .entry_flags_o,
    .status_o,
    .final_res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(madt_result_t'{kind_o, acpi_processor_id_o, apic_id_o, entry_flags_o,
                                     mpep_pkg::status_e'(status_o), final_res_o});
  end

  // ends the run when neither side moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_byte(b, l);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
  endtask

  // builds a mostly well-formed table, sometimes broken in one way
  task automatic send_table();
    logic [7:0] tbl[$];
    logic [31:0] len;
    logic [7:0] csum;
    int n_ent;
    int sz;
    int pick;
    int shape;
    for (int i = 0; i < 4; i++) tbl.push_back(SIG_TEXT[8*(3-i) +: 8]);
    repeat (40) tbl.push_back(8'($urandom));
    n_ent = $urandom_range(1, 7);
    for (int k = 0; k < n_ent; k++) begin
      tbl.push_back(($urandom_range(0, 9) < 7) ? mpep_pkg::ENTRY_TYPE_LAPIC : 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 75) sz = 8;
      else if (pick < 85) sz = $urandom_range(9, 20);
      else if (pick < 93) sz = $urandom_range(2, 7);
      else if (pick < 97) sz = 0;
      else sz = 1;
      tbl.push_back(8'(sz));
      repeat ((sz > 2) ? sz - 2 : $urandom_range(0, 6)) tbl.push_back(8'($urandom));
    end
    shape = $urandom_range(0, 99);
    len = tbl.size();
    if (shape >= 70 && shape < 76) len = len - $urandom_range(1, 7);   // cuts the last entry
    else if (shape >= 76 && shape < 80) len = $urandom();
    if (shape >= 80 && shape < 86)
      repeat ($urandom_range(1, 10)) tbl.push_back(8'($urandom));     // bytes past the length
    for (int i = 0; i < 4; i++) tbl[4+i] = len[8*i +: 8];
    csum = 8'h00;
    for (int i = 0; i < tbl.size(); i++)
      if (i != 9 && (i < 8 || i < len)) csum = csum + tbl[i];
    tbl[9] = 8'h00 - csum;
    if (shape >= 86 && shape < 91) tbl[9] = tbl[9] ^ 8'($urandom_range(1, 255));
    if (shape >= 91 && shape < 95)
      tbl[$urandom_range(0, 3)] = tbl[$urandom_range(0, 3)] ^ 8'($urandom_range(1, 255));
    if (shape >= 95) tbl = tbl[0:$urandom_range(0, tbl.size() - 2)];
    for (int i = 0; i < tbl.size(); i++) send_byte(tbl[i], i == tbl.size() - 1);
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    int pick;
    idle_by_phase  = '{0, 74, 0, 21};
    stall_by_phase = '{0, 0, 74, 21};
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (SHORT_TABLES[i]) send_byte(SHORT_TABLES[i][7:0], SHORT_TABLES[i][8]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) drain();
        if (pick < 88) send_table();
        else send_noise();
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/mpep_pkg.sv
rtl/mpep_front.sv
rtl/mpep_queue.sv
rtl/mpep_back.sv
rtl/madt_processor_entry_parser_top.sv
bench/tb.sv
